[rtl/trd_pkg.sv]
// shared types and constants of the tga rle pixel decoder
package trd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned BPP_W   = 3;
  localparam int unsigned COLOR_W = 24;

  localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
  localparam logic [BPP_W-1:0]   BPP_THREE   = 3'd3;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 32'd65536;

  localparam logic [1:0] LAST_IDX_BGR  = 2'd2;
  localparam logic [1:0] LAST_IDX_BGRA = 2'd3;

  localparam logic [BYTE_W-1:0] RUN_BIAS = 8'd127;

  typedef enum logic {
    REG_BYTES_PER_PIXEL = 1'b0,
    REG_PIXEL_COUNT     = 1'b1
  } trd_reg_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_RAW    = 3'd1,
    PH_RUN    = 3'd2,
    PH_DONE   = 3'd3,
    PH_ERROR  = 3'd4
  } trd_phase_e;

  typedef enum logic {
    ST_OK       = 1'b0,
    ST_OVERFLOW = 1'b1
  } trd_status_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_start;
  } trd_item_t;

  typedef struct packed {
    logic [BPP_W-1:0]   bytes_per_pixel;
    logic [COUNT_W-1:0] pixel_count;
  } trd_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  green;
    logic [BYTE_W-1:0]  blue;
    logic [BYTE_W-1:0]  alpha;
    logic [BYTE_W-1:0]  run_length;
    logic [COUNT_W-1:0] start_pixel;
    logic               status;
    logic               last;
  } trd_result_t;

endpackage

[rtl/trd_if.sv]
// valid/ready channel interfaces of the tga rle pixel decoder
interface trd_in_if import trd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface trd_out_if import trd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  red;
  logic [BYTE_W-1:0]  green;
  logic [BYTE_W-1:0]  blue;
  logic [BYTE_W-1:0]  alpha;
  logic [BYTE_W-1:0]  run_length;
  logic [COUNT_W-1:0] start_pixel;
  logic               status;
  logic               last;

  modport source (
    output valid, output red, output green, output blue, output alpha,
    output run_length, output start_pixel, output status, output last,
    input ready
  );
  modport sink (
    input valid, input red, input green, input blue, input alpha,
    input run_length, input start_pixel, input status, input last,
    output ready
  );
endinterface

interface trd_cfg_if import trd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               index;
  logic [COUNT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/trd_in_stage.sv]
// input register stage holding one accepted byte request
module trd_in_stage import trd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  trd_item_t item_i,
  output logic      valid_o,
  input  logic      ready_i,
  output trd_item_t item_o
);

  logic      valid_q;
  trd_item_t item_q;
  logic      load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/trd_decode.sv]
// packet state machine, pixel assembly and result register
module trd_decode import trd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  trd_cfg_t    cfg_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  trd_item_t   item_i,
  output logic        valid_o,
  input  logic        ready_i,
  output trd_result_t result_o
);

  trd_phase_e         phase_q, phase_d;
  logic [BYTE_W-1:0]  remain_q, remain_d;
  logic [1:0]         bip_q, bip_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic [COUNT_W-1:0] pos_q, pos_d;

  logic               out_valid_q;
  trd_result_t        out_q;

  trd_phase_e         cur_phase;
  logic [BYTE_W-1:0]  cur_remain;
  logic [1:0]         cur_bip;
  logic [COLOR_W-1:0] cur_color;
  logic [COUNT_W-1:0] cur_pos;

  logic               advance;
  logic [BYTE_W-1:0]  byte_v;
  logic               is_raw;
  logic [BYTE_W-1:0]  hdr_len;
  logic               overflow;
  logic [1:0]         last_idx;
  logic               pix_done;
  logic [BYTE_W-1:0]  pix_len;
  logic [BYTE_W-1:0]  remain_next;
  logic [COUNT_W-1:0] pos_next;
  logic               fin;
  logic               emit;
  trd_result_t        res;

  assign advance = valid_i && (!out_valid_q || ready_i);
  assign ready_o = !out_valid_q || ready_i;
  assign byte_v  = item_i.data_byte;

  // frame start clears the running state before this byte is used
  always_comb begin
    if (item_i.frame_start) begin
      cur_phase  = PH_HEADER;
      cur_remain = '0;
      cur_bip    = '0;
      cur_color  = '0;
      cur_pos    = '0;
    end else begin
      cur_phase  = phase_q;
      cur_remain = remain_q;
      cur_bip    = bip_q;
      cur_color  = color_q;
      cur_pos    = pos_q;
    end
  end

  assign is_raw   = !byte_v[BYTE_W-1];
  assign hdr_len  = is_raw ? (byte_v + 8'd1) : (byte_v - RUN_BIAS);
  assign overflow = ({1'b0, cur_pos} + {{(COUNT_W-BYTE_W+1){1'b0}}, hdr_len})
                    > {1'b0, cfg_i.pixel_count};
  assign last_idx = (cfg_i.bytes_per_pixel == BPP_THREE) ? LAST_IDX_BGR : LAST_IDX_BGRA;
  assign pix_done = cur_bip >= last_idx;

  assign pix_len     = (cur_phase == PH_RAW) ? 8'd1 : cur_remain;
  assign remain_next = (cur_phase == PH_RAW) ? (cur_remain - 8'd1) : '0;
  assign pos_next    = cur_pos + {{(COUNT_W-BYTE_W){1'b0}}, pix_len};
  assign fin         = pos_next >= cfg_i.pixel_count;

  // next phase
  always_comb begin
    phase_d = cur_phase;
    case (cur_phase)
      PH_HEADER: begin
        if (overflow) begin
          phase_d = PH_ERROR;
        end else if (is_raw) begin
          phase_d = PH_RAW;
        end else begin
          phase_d = PH_RUN;
        end
      end
      PH_RAW, PH_RUN: begin
        if (pix_done && (remain_next == '0)) begin
          phase_d = fin ? PH_DONE : PH_HEADER;
        end
      end
      PH_DONE:  phase_d = PH_DONE;
      PH_ERROR: phase_d = PH_ERROR;
      default:  phase_d = PH_HEADER;
    endcase
  end

  // datapath and result
  always_comb begin
    remain_d = cur_remain;
    bip_d    = cur_bip;
    color_d  = cur_color;
    pos_d    = cur_pos;
    emit     = 1'b0;
    res      = '0;
    case (cur_phase)
      PH_HEADER: begin
        if (overflow) begin
          emit            = 1'b1;
          res.run_length  = hdr_len;
          res.start_pixel = cur_pos;
          res.status      = ST_OVERFLOW;
          res.last        = 1'b1;
        end else begin
          remain_d = hdr_len;
          bip_d    = '0;
          color_d  = '0;
        end
      end
      PH_RAW, PH_RUN: begin
        if (!pix_done) begin
          case (cur_bip)
            2'd0:    color_d[7:0]   = byte_v;
            2'd1:    color_d[15:8]  = byte_v;
            default: color_d[23:16] = byte_v;
          endcase
          bip_d = cur_bip + 2'd1;
        end else begin
          emit      = 1'b1;
          res.blue  = cur_color[7:0];
          res.green = cur_color[15:8];
          if (last_idx == LAST_IDX_BGR) begin
            res.red   = byte_v;
            res.alpha = '0;
          end else begin
            res.red   = cur_color[23:16];
            res.alpha = byte_v;
          end
          res.run_length  = pix_len;
          res.start_pixel = cur_pos;
          res.status      = ST_OK;
          res.last        = fin;
          bip_d           = '0;
          color_d         = '0;
          remain_d        = remain_next;
          pos_d           = pos_next;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      remain_q <= '0;
      bip_q    <= '0;
      color_q  <= '0;
      pos_q    <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      bip_q    <= bip_d;
      color_q  <= color_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = out_q;

endmodule

[rtl/tga_rle_pixel_decoder_unit.sv]
// top level of the tga rle pixel decoder
//
//   channel    dir  modport  payload
//   pix_in_i   in   sink     data_byte, frame_start
//   pix_out_o  out  source   red, green, blue, alpha, run_length, start_pixel, status, last
//   cfg_i      in   sink     index (0 bytes_per_pixel, 1 pixel_count), data
//
// one byte request per cycle while the result register is not stalled; each byte
// passes the input register, then is decoded into the result register
// reset sets bytes_per_pixel to 4, pixel_count to 65536 and clears packet state
// a stalled result holds in the result register while the input register still
// takes one more byte; config writes are always taken
module tga_rle_pixel_decoder_unit import trd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  trd_in_if.sink    pix_in_i,
  trd_out_if.source pix_out_o,
  trd_cfg_if.sink   cfg_i
);

  trd_cfg_t    cfg_q;
  trd_item_t   in_item;
  trd_item_t   stage_item;
  logic        stage_valid;
  logic        stage_ready;
  trd_result_t result;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_pixel <= BPP_RESET;
      cfg_q.pixel_count     <= COUNT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BYTES_PER_PIXEL: cfg_q.bytes_per_pixel <= cfg_i.data[BPP_W-1:0];
        REG_PIXEL_COUNT:     cfg_q.pixel_count     <= cfg_i.data;
        default:             cfg_q                 <= cfg_q;
      endcase
    end
  end

  assign in_item.data_byte   = pix_in_i.data_byte;
  assign in_item.frame_start = pix_in_i.frame_start;

  trd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_in_i.valid),
    .ready_o (pix_in_i.ready),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .ready_i (stage_ready),
    .item_o  (stage_item)
  );

  trd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (stage_valid),
    .ready_o  (stage_ready),
    .item_i   (stage_item),
    .valid_o  (pix_out_o.valid),
    .ready_i  (pix_out_o.ready),
    .result_o (result)
  );

  assign pix_out_o.red         = result.red;
  assign pix_out_o.green       = result.green;
  assign pix_out_o.blue        = result.blue;
  assign pix_out_o.alpha       = result.alpha;
  assign pix_out_o.run_length  = result.run_length;
  assign pix_out_o.start_pixel = result.start_pixel;
  assign pix_out_o.status      = result.status;
  assign pix_out_o.last        = result.last;

endmodule
